/* sv/iirdf1_pkg.sv */
`default_nettype none

package iirdf1_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 32;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = PROD_W + 4;
  localparam int FRAC_SHIFT = 28;
  localparam int RND_W      = ACC_W - FRAC_SHIFT;

  localparam int FF_TAPS    = 5;
  localparam int FB_TAPS    = 5;

  localparam int HIST_DEPTH = 4;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);

  localparam int STEP_W     = 4;
  localparam logic [STEP_W-1:0] STEP_LAST_MUL = STEP_W'(8);
  localparam logic [STEP_W-1:0] STEP_LAST_ACC = STEP_W'(9);
  localparam logic [STEP_W-1:0] STEP_DONE     = STEP_W'(10);

  localparam logic [COEF_W-1:0] B0_RESET = COEF_W'(32'h1000_0000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_B0_B1 = 3'd0,
    CFG_B2_B3 = 3'd1,
    CFG_B4    = 3'd2,
    CFG_A1_A2 = 3'd3,
    CFG_A3_A4 = 3'd4
  } cfg_idx_t;

endpackage

`default_nettype wire

/* sv/iir_direct_form_one_filter.sv */
`default_nettype none

// channel  dir  signals                               word contents
// in       in   in_tvalid in_tready in_tdata[15:0]    sample_in
// out      out  out_tvalid out_tready out_tdata[15:0] sample_out
//                out_tuser[0]                         clipped
// cfg      in   cfg_we cfg_idx[2:0] cfg_wdata[63:0]   coefficient register write
//
// each sample runs through nine multiplies on one 16x32 multiplier, a step
// that drains the product register and a step that rounds, saturates and
// writes the history entry back to the history ram.
// reset clears the pointer and the four entry valid bits; unwritten entries read as zero.
// one input word is buffered while a sample is at work; a full output register
// holds the engine in its last step until the word is taken.

module iir_direct_form_one_filter (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [iirdf1_pkg::SAMPLE_W-1:0]     in_tdata,   // [15:0] sample_in
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [iirdf1_pkg::SAMPLE_W-1:0]          out_tdata,  // [15:0] sample_out
  output logic                                     out_tuser,  // [0] clipped
  input  wire logic                                cfg_we,
  input  wire logic [iirdf1_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [iirdf1_pkg::CFG_W-1:0]        cfg_wdata
);

  import iirdf1_pkg::*;

  // coefficients
  logic [COEF_W-1:0] coef_b_r [0:4];
  logic [COEF_W-1:0] coef_a_r [1:4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_b_r[0] <= B0_RESET;
      coef_b_r[1] <= '0;
      coef_b_r[2] <= '0;
      coef_b_r[3] <= '0;
      coef_b_r[4] <= '0;
      coef_a_r[1] <= '0;
      coef_a_r[2] <= '0;
      coef_a_r[3] <= '0;
      coef_a_r[4] <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_B0_B1: begin
          coef_b_r[0] <= cfg_wdata[COEF_W-1:0];
          coef_b_r[1] <= cfg_wdata[2*COEF_W-1:COEF_W];
        end
        CFG_B2_B3: begin
          coef_b_r[2] <= cfg_wdata[COEF_W-1:0];
          coef_b_r[3] <= cfg_wdata[2*COEF_W-1:COEF_W];
        end
        CFG_B4: begin
          coef_b_r[4] <= cfg_wdata[COEF_W-1:0];
        end
        CFG_A1_A2: begin
          coef_a_r[1] <= cfg_wdata[COEF_W-1:0];
          coef_a_r[2] <= cfg_wdata[2*COEF_W-1:COEF_W];
        end
        CFG_A3_A4: begin
          coef_a_r[3] <= cfg_wdata[COEF_W-1:0];
          coef_a_r[4] <= cfg_wdata[2*COEF_W-1:COEF_W];
        end
        default: begin
        end
      endcase
    end
  end

  // control state
  logic                  in_vld_r, in_vld_nxt;
  logic [SAMPLE_W-1:0]   in_buf_r;
  logic [SAMPLE_W-1:0]   x_cur_r;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [HIST_AW-1:0]    ptr_r;
  logic [HIST_DEPTH-1:0] hist_vld_r;
  logic                  out_vld_r, out_vld_nxt;
  logic [SAMPLE_W-1:0]   out_data_r;
  logic                  out_clip_r;

  logic start, finish;

  // history ram: one entry per past sample, {y, x}
  logic [2*SAMPLE_W-1:0] hist_mem [0:HIST_DEPTH-1];
  logic [2*SAMPLE_W-1:0] rd_data_r;
  logic                  rd_vld_r;
  logic                  rd_en;
  logic [HIST_AW-1:0]    rd_addr;

  // datapath
  logic signed [SAMPLE_W-1:0] mul_a;
  logic signed [COEF_W-1:0]   mul_b;
  logic                       mul_sub;
  logic signed [PROD_W-1:0]   mul_p;
  logic signed [PROD_W-1:0]   prod_r;
  logic                       prod_sub_r;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [ACC_W-1:0]    rnd_sum;
  logic signed [RND_W-1:0]    rnd_y;
  logic [SAMPLE_W-1:0]        y_sat;
  logic                       y_clip;
  logic [SAMPLE_W-1:0]        rd_x, rd_y;

  assign start  = (step_r == '0) && in_vld_r;
  assign finish = (step_r == STEP_DONE) && (!out_vld_r || out_tready);

  always_comb begin
    step_nxt = step_r;
    if (step_r == '0) begin
      if (in_vld_r) begin
        step_nxt = step_r + STEP_W'(1);
      end
    end else if (step_r == STEP_DONE) begin
      if (finish) begin
        step_nxt = '0;
      end
    end else begin
      step_nxt = step_r + STEP_W'(1);
    end
  end

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (start) begin
      in_vld_nxt = 1'b0;
    end
    if (in_tvalid && in_tready) begin
      in_vld_nxt = 1'b1;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (finish) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      step_r     <= '0;
      ptr_r      <= '0;
      hist_vld_r <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      step_r    <= step_nxt;
      out_vld_r <= out_vld_nxt;
      if (finish) begin
        ptr_r             <= ptr_r + HIST_AW'(1);
        hist_vld_r[ptr_r] <= 1'b1;
      end
    end
  end

  // reads at even steps 0..6 fetch entry ptr-1 .. ptr-4
  assign rd_en   = !step_r[0] && (step_r <= STEP_W'(6));
  assign rd_addr = ptr_r - HIST_AW'(step_r[2:1]) - HIST_AW'(1);

  always_ff @(posedge clk) begin
    if (finish) begin
      hist_mem[ptr_r] <= {y_sat, x_cur_r};
    end
    if (rd_en) begin
      rd_data_r <= hist_mem[rd_addr];
      rd_vld_r  <= hist_vld_r[rd_addr];
    end
  end

  assign rd_x = rd_vld_r ? rd_data_r[SAMPLE_W-1:0] : '0;
  assign rd_y = rd_vld_r ? rd_data_r[2*SAMPLE_W-1:SAMPLE_W] : '0;

  // tap schedule: step 0 is x*b0, odd steps x[n-k]*bk, even steps y[n-k]*ak
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_sub = 1'b0;
    case (step_r)
      4'd0: begin
        mul_a = in_buf_r;
        mul_b = coef_b_r[0];
      end
      4'd1: begin
        mul_a = rd_x;
        mul_b = (FF_TAPS > 1) ? coef_b_r[1] : '0;
      end
      4'd2: begin
        mul_a   = rd_y;
        mul_b   = (FB_TAPS > 1) ? coef_a_r[1] : '0;
        mul_sub = 1'b1;
      end
      4'd3: begin
        mul_a = rd_x;
        mul_b = (FF_TAPS > 2) ? coef_b_r[2] : '0;
      end
      4'd4: begin
        mul_a   = rd_y;
        mul_b   = (FB_TAPS > 2) ? coef_a_r[2] : '0;
        mul_sub = 1'b1;
      end
      4'd5: begin
        mul_a = rd_x;
        mul_b = (FF_TAPS > 3) ? coef_b_r[3] : '0;
      end
      4'd6: begin
        mul_a   = rd_y;
        mul_b   = (FB_TAPS > 3) ? coef_a_r[3] : '0;
        mul_sub = 1'b1;
      end
      4'd7: begin
        mul_a = rd_x;
        mul_b = (FF_TAPS > 4) ? coef_b_r[4] : '0;
      end
      STEP_LAST_MUL: begin
        mul_a   = rd_y;
        mul_b   = (FB_TAPS > 4) ? coef_a_r[4] : '0;
        mul_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_ext = ACC_W'(prod_r);

  always_comb begin
    acc_nxt = acc_r;
    if (step_r == STEP_W'(1)) begin
      acc_nxt = prod_sub_r ? -prod_ext : prod_ext;
    end else if (step_r >= STEP_W'(2) && step_r <= STEP_LAST_ACC) begin
      acc_nxt = prod_sub_r ? acc_r - prod_ext : acc_r + prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= mul_p;
    prod_sub_r <= mul_sub;
    acc_r      <= acc_nxt;
    if (start) begin
      x_cur_r <= in_buf_r;
    end
    if (in_tvalid && in_tready) begin
      in_buf_r <= in_tdata;
    end
    if (finish) begin
      out_data_r <= y_sat;
      out_clip_r <= y_clip;
    end
  end

  // round half up, then saturate to 16 bits
  assign rnd_sum = acc_r + (ACC_W'(1) <<< (FRAC_SHIFT - 1));
  assign rnd_y   = rnd_sum[ACC_W-1:FRAC_SHIFT];

  always_comb begin
    y_sat  = rnd_y[SAMPLE_W-1:0];
    y_clip = 1'b0;
    if (rnd_y[RND_W-1:SAMPLE_W-1] != {(RND_W-SAMPLE_W+1){rnd_y[RND_W-1]}}) begin
      y_clip = 1'b1;
      y_sat  = rnd_y[RND_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  assign in_tready  = !in_vld_r;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_clip_r;

  // checks
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_DONE)
    else $error("step counter out of range");

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (step_r == STEP_W'(1)))
    else $error("engine did not pick up buffered word");

  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> out_vld_r && (out_tdata == $past(y_sat)))
    else $error("finished sample not presented");

  a_ptr_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != STEP_DONE) |=> $stable(ptr_r))
    else $error("history pointer moved outside write-back");

endmodule

`default_nettype wire
